// File: hw/rtl/qrs_pkg.sv
// Shared constants for the quadratic root solver.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int ROOT_W = 33;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOREAL = 2'd1;
    localparam logic [1:0] ST_ZEROA  = 2'd2;

endpackage

// File: hw/rtl/polynomial_root_solver.sv
// Pipelined linear / quadratic root solver with fixed-point square root and dividers.
// Path: capture, products, discriminant, sqrt, numerators, dividers, result register.
// Throughput: one request per cycle; a request with two roots holds busy for a single cycle
// while the second root goes out, since both roots share the one result port.
// Work: 2 multipliers in one stage, one sqrt stage per root bit, two dividers one bit per stage.
// Reset clears valid bits and the pending second-root flag; the receiver cannot stall.
`timescale 1ns / 1ps

module polynomial_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     op,
    input  logic [COEF_BITS-1:0]     coef_a,
    input  logic [COEF_BITS-1:0]     coef_b,
    input  logic [COEF_BITS-1:0]     coef_c,
    output logic                     strobe,
    output logic signed [ROOT_W-1:0] root,
    output logic [1:0]               status,
    output logic                     last
);

    localparam int C   = COEF_BITS;
    localparam int N   = COEF_BITS + FRAC_BITS;   // sqrt result bits
    localparam int RW  = 2 * N;                   // radicand bits
    localparam int NW  = N + 1;                   // numerator / quotient bits
    localparam int MW  = (NW > ROOT_W) ? NW : ROOT_W;
    localparam logic [MW-1:0] MAG_LIM = MW'(1) << (ROOT_W - 1);

    typedef struct packed {
        logic [1:0]   st;
        logic         two;
        logic [N-1:0] bq;
        logic [C:0]   den;
    } sq_pay_t;

    typedef struct packed {
        logic [1:0] st;
        logic       two;
        logic [C:0] den;
    } dv_pay_t;

    function automatic logic [ROOT_W-1:0] neg_sat(input logic [NW-1:0] m);
        logic [MW-1:0] me;
        me = MW'(m);
        if (me > MAG_LIM)
        begin
            me = MAG_LIM;
        end
        return ROOT_W'(0) - me[ROOT_W-1:0];
    endfunction

    logic adv;
    logic pend_reg;
    logic [ROOT_W-1:0] pend_root_reg;

    assign adv  = !pend_reg;
    assign busy = pend_reg;

    // stage 1: capture
    logic         v1_reg;
    logic         op1_reg;
    logic [C-1:0] a1_reg, b1_reg, c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg <= op;
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            c1_reg  <= coef_c;
        end
    end

    // stage 2: products
    logic           v2_reg;
    logic           op2_reg;
    logic [C-1:0]   a2_reg, b2_reg;
    logic [2*C-1:0] bb2_reg, ac2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg <= op1_reg;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            bb2_reg <= (2*C)'(b1_reg) * (2*C)'(b1_reg);
            ac2_reg <= (2*C)'(a1_reg) * (2*C)'(c1_reg);
        end
    end

    // stage 3: discriminant, status
    logic           neg_disc;
    logic [2*C-1:0] disc;
    logic [1:0]     st_next;
    logic           v3_reg;
    sq_pay_t        pay3_reg;
    logic [RW-1:0]  rad3_reg;

    assign neg_disc = {ac2_reg, 2'b00} > {2'b00, bb2_reg};
    assign disc     = bb2_reg - (ac2_reg << 2);

    always_comb
    begin
        if (a2_reg == '0)
            st_next = ST_ZEROA;
        else if (op2_reg && neg_disc)
            st_next = ST_NOREAL;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay3_reg.st  <= st_next;
            pay3_reg.two <= op2_reg && (st_next == ST_OK) && (disc != '0);
            pay3_reg.bq  <= N'(b2_reg) << FRAC_BITS;
            pay3_reg.den <= op2_reg ? {a2_reg, 1'b0} : {1'b0, a2_reg};
            rad3_reg     <= op2_reg ? (RW'(disc) << (2 * FRAC_BITS)) : '0;
        end
    end

    // square root: one result bit per stage
    logic          sq_v_reg   [0:N-1];
    sq_pay_t       sq_pay_reg [0:N-1];
    logic [RW-1:0] sq_rad_reg [0:N-1];
    logic [N+1:0]  sq_rem_reg [0:N-1];
    logic [N-1:0]  sq_rt_reg  [0:N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_sq
        logic          in_v;
        sq_pay_t       in_pay;
        logic [RW-1:0] in_rad;
        logic [N+1:0]  in_rem;
        logic [N-1:0]  in_rt;
        logic [N+1:0]  rem_sh;
        logic [N+1:0]  trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign in_v   = v3_reg;
            assign in_pay = pay3_reg;
            assign in_rad = rad3_reg;
            assign in_rem = '0;
            assign in_rt  = '0;
        end
        else
        begin : g_rest
            assign in_v   = sq_v_reg[k-1];
            assign in_pay = sq_pay_reg[k-1];
            assign in_rad = sq_rad_reg[k-1];
            assign in_rem = sq_rem_reg[k-1];
            assign in_rt  = sq_rt_reg[k-1];
        end

        assign rem_sh = {in_rem[N-1:0], in_rad[RW-1:RW-2]};
        assign trial  = {in_rt, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k] <= in_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_pay_reg[k] <= in_pay;
                sq_rad_reg[k] <= in_rad << 2;
                sq_rem_reg[k] <= ge ? (rem_sh - trial) : rem_sh;
                sq_rt_reg[k]  <= {in_rt[N-2:0], ge};
            end
        end
    end

    // numerators for both roots
    logic          v4_reg;
    dv_pay_t       pay4_reg;
    logic [NW-1:0] n1_4_reg, n2_4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= sq_v_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay4_reg.st  <= sq_pay_reg[N-1].st;
            pay4_reg.two <= sq_pay_reg[N-1].two;
            pay4_reg.den <= sq_pay_reg[N-1].den;
            n1_4_reg <= NW'(sq_pay_reg[N-1].bq) + NW'(sq_rt_reg[N-1]);
            n2_4_reg <= NW'(sq_pay_reg[N-1].bq) - NW'(sq_rt_reg[N-1]);
        end
    end

    // two restoring dividers, one quotient bit per stage
    logic          dv_v_reg    [0:NW-1];
    dv_pay_t       dv_pay_reg  [0:NW-1];
    logic [NW-1:0] dv_n1_reg   [0:NW-1];
    logic [NW-1:0] dv_n2_reg   [0:NW-1];
    logic [C:0]    dv_r1_reg   [0:NW-1];
    logic [C:0]    dv_r2_reg   [0:NW-1];

    for (genvar j = 0; j < NW; j++)
    begin : g_dv
        logic          in_v;
        dv_pay_t       in_pay;
        logic [NW-1:0] in_n1, in_n2;
        logic [C:0]    in_r1, in_r2;
        logic [C+1:0]  sh1, sh2;
        logic          ge1, ge2;

        if (j == 0)
        begin : g_first
            assign in_v   = v4_reg;
            assign in_pay = pay4_reg;
            assign in_n1  = n1_4_reg;
            assign in_n2  = n2_4_reg;
            assign in_r1  = '0;
            assign in_r2  = '0;
        end
        else
        begin : g_rest
            assign in_v   = dv_v_reg[j-1];
            assign in_pay = dv_pay_reg[j-1];
            assign in_n1  = dv_n1_reg[j-1];
            assign in_n2  = dv_n2_reg[j-1];
            assign in_r1  = dv_r1_reg[j-1];
            assign in_r2  = dv_r2_reg[j-1];
        end

        assign sh1 = {in_r1, in_n1[NW-1]};
        assign sh2 = {in_r2, in_n2[NW-1]};
        assign ge1 = sh1 >= {1'b0, in_pay.den};
        assign ge2 = sh2 >= {1'b0, in_pay.den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[j] <= in_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_pay_reg[j] <= in_pay;
                dv_n1_reg[j]  <= {in_n1[NW-2:0], ge1};
                dv_n2_reg[j]  <= {in_n2[NW-2:0], ge2};
                dv_r1_reg[j]  <= ge1 ? (C+1)'(sh1 - {1'b0, in_pay.den}) : sh1[C:0];
                dv_r2_reg[j]  <= ge2 ? (C+1)'(sh2 - {1'b0, in_pay.den}) : sh2[C:0];
            end
        end
    end

    // result port; second root waits in pend_root_reg while the pipe holds
    logic              fin_v;
    dv_pay_t           fin_pay;
    logic              strobe_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [1:0]        status_reg;
    logic              last_reg;

    assign fin_v   = dv_v_reg[NW-1];
    assign fin_pay = dv_pay_reg[NW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else if (pend_reg)
        begin
            strobe_reg <= 1'b1;
            pend_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= fin_v;
            pend_reg   <= fin_v && fin_pay.two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            root_reg   <= pend_root_reg;
            status_reg <= ST_OK;
            last_reg   <= 1'b1;
        end
        else
        begin
            root_reg      <= (fin_pay.st == ST_OK) ? neg_sat(dv_n1_reg[NW-1]) : '0;
            status_reg    <= fin_pay.st;
            last_reg      <= !fin_pay.two;
            pend_root_reg <= neg_sat(dv_n2_reg[NW-1]);
        end
    end

    assign strobe = strobe_reg;
    assign root   = root_reg;
    assign status = status_reg;
    assign last   = last_reg;

`ifndef ASSERT_OFF
    a_pend_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> strobe_reg && !last_reg && status_reg == ST_OK)
        else $error("second root pending without a first root");

    a_pend_once: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> !pend_reg && strobe_reg && last_reg)
        else $error("second root not delivered");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && status_reg != ST_OK |-> root_reg == '0 && last_reg)
        else $error("error result carries a root");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> status_reg == ST_OK || status_reg == ST_NOREAL
                       || status_reg == ST_ZEROA)
        else $error("bad status code");
`endif

endmodule

// File: tb/sv/polynomial_root_solver_checker.sv
// Checker: predicts roots of accepted requests and compares each strobed result.
`timescale 1ns / 1ps

module polynomial_root_solver_checker
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     op,
    input  logic [15:0]              coef_a,
    input  logic [15:0]              coef_b,
    input  logic [15:0]              coef_c,
    input  logic                     strobe,
    input  logic signed [ROOT_W-1:0] root,
    input  logic [1:0]               status,
    input  logic                     last,
    output int                       fail_count,
    output int                       pending,
    output int                       result_count
);

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [1:0]        status;
        logic              last;
    } root_result_t;

    root_result_t expected_roots[$];

    // floor(sqrt(d) * 2^16)
    function automatic logic [63:0] fixed_sqrt(input logic [63:0] d);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] trial;
        logic [63:0] pair;
        r = 0;
        rem = 0;
        for (int i = 0; i < 48; i++)
        begin
            pair = (i < 32) ? ((d >> (62 - 2 * i)) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (r << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                r = (r << 1) | 64'd1;
            end
            else
                r = r << 1;
        end
        return r;
    endfunction

    function automatic logic [ROOT_W-1:0] negate_mag(input logic [63:0] mag);
        logic [63:0] m;
        m = (mag > (64'd1 << 32)) ? (64'd1 << 32) : mag;
        return ROOT_W'(64'd0 - m);
    endfunction

    task automatic queue_result(input logic [ROOT_W-1:0] r, input logic [1:0] s,
                                input logic l);
        root_result_t e;
        e.root = r;
        e.status = s;
        e.last = l;
        expected_roots.insert(expected_roots.size(), e);
    endtask

    task automatic predict_roots(input logic o, input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] c);
        logic [63:0] bq;
        logic [63:0] bb;
        logic [63:0] ac;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] den;
        bq = 64'(b) << 16;
        bb = 64'(b) * 64'(b);
        ac = 64'(a) * 64'(c);
        den = 64'(a) << 1;
        if (a == 0)
            queue_result('0, ST_ZEROA, 1'b1);
        else if (o == 1'b0)
            queue_result(negate_mag(bq / 64'(a)), ST_OK, 1'b1);
        else if (ac > (bb >> 2))
            queue_result('0, ST_NOREAL, 1'b1);
        else
        begin
            d = bb - (ac << 2);
            if (d == 0)
                queue_result(negate_mag(bq / den), ST_OK, 1'b1);
            else
            begin
                s = fixed_sqrt(d);
                queue_result(negate_mag((bq + s) / den), ST_OK, 1'b0);
                queue_result(negate_mag((bq - s) / den), ST_OK, 1'b1);
            end
        end
    endtask

    always @(posedge clk)
    begin
        root_result_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            result_count = 0;
            expected_roots.delete();
            pending = 0;
        end
        else
        begin
            if (strobe)
            begin
                result_count++;
                if (expected_roots.size() == 0)
                begin
                    $display("%0t: unexpected result root=%0d status=%0d last=%0b",
                             $time, root, status, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (root !== want.root || status !== want.status
                        || last !== want.last)
                    begin
                        $display("%0t: mismatch expected root=%0d status=%0d last=%0b",
                                 $time, $signed(want.root), want.status, want.last);
                        $display("%0t:          actual   root=%0d status=%0d last=%0b",
                                 $time, root, status, last);
                        fail_count++;
                    end
                end
            end
            // predict after popping so a same-edge result never matches a new request
            if (start && !busy)
                predict_roots(op, coef_a, coef_b, coef_c);
            pending = expected_roots.size();
        end
    end

endmodule

// File: tb/sv/tb_polynomial_root_solver.sv
// Testbench top: drives requests into the root solver and reports the verdict.
`timescale 1ns / 1ps

module tb_polynomial_root_solver;
    import qrs_pkg::*;

    localparam int LATENCY = 69;
    localparam longint CYCLE_LIMIT = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     op;
    logic [15:0]              coef_a;
    logic [15:0]              coef_b;
    logic [15:0]              coef_c;
    logic                     strobe;
    logic signed [ROOT_W-1:0] root;
    logic [1:0]               status;
    logic                     last;
    int                       fail_count;
    int                       pending;
    int                       result_count;
    longint                   cycle_count;
    int                       sent;

    polynomial_root_solver uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .strobe(strobe), .root(root), .status(status), .last(last)
    );

    polynomial_root_solver_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .strobe(strobe), .root(root), .status(status), .last(last),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one request, hold it until accepted
    task automatic send_request(input logic o, input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] c, input bit allow_gap);
        if (allow_gap)
        begin
            while ($urandom_range(99) < 21)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        op <= o;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'($urandom_range(15));
            1: return 16'hFFFF - 16'($urandom_range(15));
            2: return 16'(1 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] r1;
        logic [15:0] r2;
        int          wait_cycles;
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = 1'b0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero leading coefficient, extremes, each discriminant sign
        send_request(1'b0, 16'd0, 16'd5, 16'd0, 1'b0);
        send_request(1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_request(1'b0, 16'd1, 16'hFFFF, 16'd0, 1'b0);
        send_request(1'b0, 16'hFFFF, 16'd1, 16'hFFFF, 1'b0);
        send_request(1'b0, 16'd3, 16'd0, 16'd7, 1'b0);
        send_request(1'b0, 16'd7, 16'd22, 16'd0, 1'b0);
        send_request(1'b1, 16'd1, 16'd0, 16'd1, 1'b0);
        send_request(1'b1, 16'hFFFF, 16'd1, 16'hFFFF, 1'b0);
        send_request(1'b1, 16'd1, 16'd2, 16'd1, 1'b0);
        send_request(1'b1, 16'd3, 16'd12, 16'd12, 1'b0);
        send_request(1'b1, 16'd1, 16'hFFFE, 16'h7FFF, 1'b0);
        send_request(1'b1, 16'd1, 16'd5, 16'd6, 1'b0);
        send_request(1'b1, 16'd1, 16'hFFFF, 16'd0, 1'b0);
        send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
        send_request(1'b1, 16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_request(1'b1, 16'd2, 16'd3, 16'd1, 1'b0);
        send_request(1'b1, 16'd1, 16'd0, 16'd0, 1'b0);
        send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);

        for (int n = 0; n < 540; n++)
        begin
            a = rand_coef();
            b = rand_coef();
            c = rand_coef();
            case ($urandom_range(9))
                0, 1: send_request(1'b0, a, b, c, (n < 200 || n > 300));
                2: send_request(1'($urandom_range(1)), 16'd0, b, c, (n < 200 || n > 300));
                3:
                begin
                    // perfect square: (r1*x + r2)^2 gives a zero discriminant unless 2*r1*r2 overflows 16 bits
                    r1 = 16'($urandom_range(1, 255));
                    r2 = 16'($urandom_range(255));
                    send_request(1'b1, r1 * r1, 16'd2 * r1 * r2, r2 * r2,
                                 (n < 200 || n > 300));
                end
                4, 5:
                begin
                    // factored (x + r1)(x + r2) with real roots
                    r1 = 16'($urandom_range(255));
                    r2 = 16'($urandom_range(255));
                    send_request(1'b1, 16'd1, r1 + r2, r1 * r2, (n < 200 || n > 300));
                end
                default: send_request(1'b1, a, b, c, (n < 200 || n > 300));
            endcase
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < LATENCY + 10)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("sent %0d requests (linear, quadratic, zero leading coefficient),", sent);
        $display("checked %0d results across all discriminant signs", result_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
